### design/lz4_block_size_scanner_unit_defines.svh
// ----------------------------------------------------------------------------
// lz4 block size scanner assertion macros
// shared assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef LZ4_BLOCK_SIZE_SCANNER_UNIT_DEFINES_SVH
`define LZ4_BLOCK_SIZE_SCANNER_UNIT_DEFINES_SVH

`ifndef SYNTH
// checked property, skipped while reset is high
`define LBS_ASSERT(lbl, clock, reset, prop, msg) \
  lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// checked property, also during reset
`define LBS_ASSERT_ALWAYS(lbl, clock, prop, msg) \
  lbl: assert property (@(posedge clock) (prop)) else $error(msg);
`else
`define LBS_ASSERT(lbl, clock, reset, prop, msg)
`define LBS_ASSERT_ALWAYS(lbl, clock, prop, msg)
`endif

`endif

### design/lz4bs_pkg.sv
// ----------------------------------------------------------------------------
// lz4 block size scanner package
// phase and status codes, scan state type and the saturating size add
// ----------------------------------------------------------------------------
package lz4bs_pkg;

  // width of the decoded size accumulator
  localparam int SIZE_BITS = 32;
  // width used to compare a 16-bit offset against the size
  localparam int CMP_W = (SIZE_BITS > 16) ? SIZE_BITS : 16;

  localparam logic [3:0] NIBBLE_EXT  = 4'hf;  // nibble that asks for extension bytes
  localparam logic [7:0] EXT_MORE    = 8'hff; // extension byte that continues the run
  localparam logic [2:0] MATCH_BIAS  = 3'd4;  // minimum match length

  typedef enum logic [2:0] {
    PH_TOKEN     = 3'd0,
    PH_LIT_EXT   = 3'd1,
    PH_LITERALS  = 3'd2,
    PH_OFF_LO    = 3'd3,
    PH_OFF_HI    = 3'd4,
    PH_MATCH_EXT = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_INVALID_END = 2'd1,
    ST_OVERFLOW    = 2'd2
  } status_t;

  typedef struct packed {
    phase_t                 phase;
    logic [31:0]            literal_remaining;
    logic [SIZE_BITS-1:0]   size_total;
    logic [7:0]             offset_low;
    logic [15:0]            link_max;
    logic [3:0]             match_nibble;
    logic                   overflowed;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    phase:             PH_TOKEN,
    literal_remaining: 32'd0,
    size_total:        '0,
    offset_low:        8'd0,
    link_max:          16'd0,
    match_nibble:      4'd0,
    overflowed:        1'b0
  };

  typedef struct packed {
    logic [SIZE_BITS-1:0] value;
    logic                 ovf;
  } sat_sum_t;

  // add with saturation at all ones
  function automatic sat_sum_t size_add(input logic [SIZE_BITS-1:0] cur,
                                        input logic [SIZE_BITS-1:0] amt);
    logic [SIZE_BITS:0] s;
    sat_sum_t           r;
    s       = {1'b0, cur} + {1'b0, amt};
    r.ovf   = s[SIZE_BITS];
    r.value = s[SIZE_BITS] ? '1 : s[SIZE_BITS-1:0];
    return r;
  endfunction

endpackage

### design/lz4bs_step.sv
// ----------------------------------------------------------------------------
// lz4 block size scanner step
// next scan state for one compressed byte, one shared size adder
// ----------------------------------------------------------------------------
module lz4bs_step (
  input  lz4bs_pkg::scan_state_t cur,
  input  logic [7:0]             data_byte,
  output lz4bs_pkg::scan_state_t nxt
);

  logic [lz4bs_pkg::SIZE_BITS-1:0] size_amt;
  lz4bs_pkg::sat_sum_t             size_sum;
  logic [32:0]                     lit_sum;
  logic [31:0]                     lit_dec;
  logic [15:0]                     offset;
  logic [lz4bs_pkg::CMP_W-1:0]     offset_ext;
  logic [lz4bs_pkg::CMP_W-1:0]     size_ext;
  logic [lz4bs_pkg::CMP_W-1:0]     reach;

  // amount for the shared size adder
  always_comb begin
    case (cur.phase)
      lz4bs_pkg::PH_LIT_EXT,
      lz4bs_pkg::PH_MATCH_EXT: size_amt = lz4bs_pkg::SIZE_BITS'(data_byte);
      lz4bs_pkg::PH_OFF_HI:    size_amt = lz4bs_pkg::SIZE_BITS'(cur.match_nibble)
                                          + lz4bs_pkg::SIZE_BITS'(lz4bs_pkg::MATCH_BIAS);
      lz4bs_pkg::PH_LITERALS,
      lz4bs_pkg::PH_OFF_LO:    size_amt = '0;
      default:                 size_amt = lz4bs_pkg::SIZE_BITS'(data_byte[7:4]);
    endcase
  end

  assign size_sum   = lz4bs_pkg::size_add(cur.size_total, size_amt);
  assign lit_sum    = {1'b0, cur.literal_remaining} + {25'd0, data_byte};
  assign lit_dec    = (cur.literal_remaining != 32'd0) ? cur.literal_remaining - 32'd1
                                                       : cur.literal_remaining;
  assign offset     = {data_byte, cur.offset_low};
  assign offset_ext = lz4bs_pkg::CMP_W'(offset);
  assign size_ext   = lz4bs_pkg::CMP_W'(cur.size_total);
  assign reach      = offset_ext - size_ext;

  always_comb begin
    nxt = cur;
    case (cur.phase)
      lz4bs_pkg::PH_LIT_EXT: begin
        nxt.size_total = size_sum.value;
        if (lit_sum[32]) begin
          nxt.literal_remaining = '1;
        end else begin
          nxt.literal_remaining = lit_sum[31:0];
        end
        nxt.overflowed = cur.overflowed | size_sum.ovf | lit_sum[32];
        if (data_byte != lz4bs_pkg::EXT_MORE) begin
          nxt.phase = lz4bs_pkg::PH_LITERALS;
        end
      end
      lz4bs_pkg::PH_LITERALS: begin
        nxt.literal_remaining = lit_dec;
        if (lit_dec == 32'd0) begin
          nxt.phase = lz4bs_pkg::PH_OFF_LO;
        end
      end
      lz4bs_pkg::PH_OFF_LO: begin
        nxt.offset_low = data_byte;
        nxt.phase      = lz4bs_pkg::PH_OFF_HI;
      end
      lz4bs_pkg::PH_OFF_HI: begin
        // reach before block start, kept only when positive and larger
        if (offset_ext > size_ext && reach[15:0] > cur.link_max) begin
          nxt.link_max = reach[15:0];
        end
        nxt.size_total = size_sum.value;
        nxt.overflowed = cur.overflowed | size_sum.ovf;
        nxt.phase = (cur.match_nibble == lz4bs_pkg::NIBBLE_EXT) ? lz4bs_pkg::PH_MATCH_EXT
                                                                 : lz4bs_pkg::PH_TOKEN;
      end
      lz4bs_pkg::PH_MATCH_EXT: begin
        nxt.size_total = size_sum.value;
        nxt.overflowed = cur.overflowed | size_sum.ovf;
        if (data_byte != lz4bs_pkg::EXT_MORE) begin
          nxt.phase = lz4bs_pkg::PH_TOKEN;
        end
      end
      default: begin
        // token, also taken for unused phase codes
        nxt.match_nibble      = data_byte[3:0];
        nxt.literal_remaining = 32'(data_byte[7:4]);
        nxt.size_total        = size_sum.value;
        nxt.overflowed        = cur.overflowed | size_sum.ovf;
        if (data_byte[7:4] == lz4bs_pkg::NIBBLE_EXT) begin
          nxt.phase = lz4bs_pkg::PH_LIT_EXT;
        end else if (data_byte[7:4] != 4'd0) begin
          nxt.phase = lz4bs_pkg::PH_LITERALS;
        end else begin
          nxt.phase = lz4bs_pkg::PH_OFF_LO;
        end
      end
    endcase
  end

endmodule

### design/lz4_block_size_scanner_unit.sv
// ----------------------------------------------------------------------------
// lz4 block size scanner unit
// walks an lz4 block byte by byte and reports decoded size and link distance
// ----------------------------------------------------------------------------
// usage
//   input channel: one compressed byte per beat on data_byte, with block_end
//   high on the last byte of the block; in_valid / in_ready handshake
//   output channel: one beat per block, carrying decoded_size, link_distance
//   and status; out_valid / out_ready handshake
//   throughput: one byte per cycle, sustained, through a one-byte input
//   register and a result register; the only stall is a final byte that
//   finds the result register still full and not being taken
//   result timing: a block's result shows on out_valid in the cycle after the
//   edge that moves its final byte out of the input register, which waits
//   until the result register is free or being taken
//   non-final bytes flow through even while the receiver stalls
//   reset (rst, synchronous): input and result registers empty, scan state
//   back to expecting a token with all counts at zero
//   after a final byte the scan state clears for the next block
// ----------------------------------------------------------------------------
`include "lz4_block_size_scanner_unit_defines.svh"

module lz4_block_size_scanner_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        block_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] decoded_size,
  output logic [15:0] link_distance,
  output logic [1:0]  status
);

  // input register
  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       stage_end;
  logic       stage_adv;
  logic       in_fire;

  // scan state
  lz4bs_pkg::scan_state_t state;
  lz4bs_pkg::scan_state_t step_next;
  lz4bs_pkg::status_t     status_next;

  // a final byte needs a free result slot, other bytes always move on
  assign stage_adv = stage_valid & (~stage_end | ~out_valid | out_ready);
  assign in_ready  = ~stage_valid | stage_adv;
  assign in_fire   = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_fire) begin
      stage_valid <= 1'b1;
    end else if (stage_adv) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stage_byte <= data_byte;
      stage_end  <= block_end;
    end
  end

  lz4bs_step u_step (
    .cur       (state),
    .data_byte (stage_byte),
    .nxt       (step_next)
  );

  // block ends well only right after a literal run
  always_comb begin
    if (step_next.phase != lz4bs_pkg::PH_OFF_LO) begin
      status_next = lz4bs_pkg::ST_INVALID_END;
    end else if (step_next.overflowed) begin
      status_next = lz4bs_pkg::ST_OVERFLOW;
    end else begin
      status_next = lz4bs_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lz4bs_pkg::SCAN_RESET;
    end else if (stage_adv) begin
      state <= stage_end ? lz4bs_pkg::SCAN_RESET : step_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_adv && stage_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_adv && stage_end) begin
      decoded_size  <= 32'(step_next.size_total);
      link_distance <= step_next.link_max;
      status        <= status_next;
    end
  end

  // a final byte clears the scan state
  `LBS_ASSERT(a_clear_after_end, clk, rst, stage_adv && stage_end |=> state == lz4bs_pkg::SCAN_RESET, "scan state not cleared after final byte")
  // a final byte always produces a result beat
  `LBS_ASSERT(a_result_after_end, clk, rst, stage_adv && stage_end |=> out_valid, "final byte left no result")
  // input held off only by a final byte waiting on a full result register
  `LBS_ASSERT(a_ready_cause, clk, rst, !in_ready |-> stage_valid && stage_end && out_valid && !out_ready, "input stalled without cause")
  // while in reset both registers stay empty
  `LBS_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !stage_valid && !out_valid, "registers not empty after reset")

endmodule
